/* rtl/core/char_stream_binary_expression_eval_macros.svh */
// Assertion helpers for the checker file.
`ifndef CHAR_STREAM_BINARY_EXPRESSION_EVAL_MACROS_SVH
`define CHAR_STREAM_BINARY_EXPRESSION_EVAL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/cse_pkg.sv */
package cse_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int RES_W          = 32;
	localparam int EXT_W          = 64;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_OP    = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	// parser -> arithmetic unit
	typedef struct packed {
		logic start;
		op_t  op;
		logic has_op;
	} cse_req_t;

	// arithmetic unit -> top
	typedef struct packed {
		logic    busy;
		logic    done;
		status_t status;
	} cse_alu_stat_t;

endpackage

/* rtl/core/cse_parser.sv */
module cse_parser import cse_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_en,   // accepted non-terminator character
	input  logic                  clear,     // terminator accepted
	input  logic [7:0]            char_in,
	output logic [DATA_WIDTH-1:0] left_val,  // sign already applied
	output logic [DATA_WIDTH-1:0] right_val,
	output op_t                   op,
	output logic                  has_op
);

	logic [DATA_WIDTH-1:0] left_q, right_q;
	op_t                   op_q;
	logic                  in_right_q, neg_q, seen_q;

	logic                  is_blank, is_digit, is_op;
	logic [DATA_WIDTH-1:0] digit, acc_sel, acc_next;
	op_t                   op_dec;

	always_comb begin
		is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB);
		is_digit = char_in inside {[CH_ZERO:CH_NINE]};
		is_op    = 1'b1;
		op_dec   = OP_ADD;
		case (char_in)
			CH_PLUS:  op_dec = OP_ADD;
			CH_MINUS: op_dec = OP_SUB;
			CH_MUL:   op_dec = OP_MUL;
			CH_DIV:   op_dec = OP_DIV;
			default:  is_op  = 1'b0;
		endcase
		digit    = DATA_WIDTH'(char_in - CH_ZERO);
		acc_sel  = in_right_q ? right_q : left_q;
		// x*10 + d as two shifts and two adds
		acc_next = (acc_sel << 3) + (acc_sel << 1) + digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			right_q    <= '0;
			op_q       <= OP_ADD;
			in_right_q <= 1'b0;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
		end else if (clear) begin
			left_q     <= '0;
			right_q    <= '0;
			op_q       <= OP_ADD;
			in_right_q <= 1'b0;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
		end else if (char_en && !is_blank) begin
			if (!in_right_q) begin
				if (!seen_q && char_in == CH_MINUS) begin
					neg_q <= 1'b1;
				end else if (is_op) begin
					op_q       <= op_dec;
					in_right_q <= 1'b1;
				end else if (is_digit) begin
					left_q <= acc_next;
				end
				seen_q <= 1'b1;
			end else if (is_digit) begin
				right_q <= acc_next;
			end
		end
	end

	assign left_val  = neg_q ? ('0 - left_q) : left_q;
	assign right_val = right_q;
	assign op        = op_q;
	assign has_op    = in_right_q;

endmodule

/* rtl/core/cse_alu.sv */
module cse_alu import cse_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cse_req_t              req,
	input  logic [DATA_WIDTH-1:0] l_in,
	input  logic [DATA_WIDTH-1:0] r_in,
	output logic [DATA_WIDTH-1:0] res,
	output cse_alu_stat_t         stat
);

	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam int ADD_W = DATA_WIDTH + 2;

	typedef enum logic [2:0] {
		A_IDLE,
		A_ADDSUB,
		A_MUL,
		A_DIV,
		A_SIGN,
		A_DONE
	} a_state_t;

	a_state_t              state_q;
	logic [DATA_WIDTH-1:0] a_q, b_q, rem_q, res_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	op_t                   op_q;
	status_t               status_q;

	// the one shared adder/subtractor
	logic [ADD_W-1:0]      ax, bx, sum;
	logic                  sub, ge;
	logic [DATA_WIDTH-1:0] l_abs, r_abs, acc_next;

	always_comb begin
		ax  = '0;
		bx  = '0;
		sub = 1'b0;
		case (state_q)
			A_ADDSUB: begin
				ax  = ADD_W'(a_q);
				bx  = ADD_W'(b_q);
				sub = (op_q == OP_SUB);
			end
			A_MUL: begin
				ax = ADD_W'(rem_q);
				bx = ADD_W'(a_q);
			end
			A_DIV: begin
				ax  = ADD_W'({rem_q, a_q[DATA_WIDTH-1]});
				bx  = ADD_W'(b_q);
				sub = 1'b1;
			end
			A_SIGN: begin
				bx  = ADD_W'(a_q);
				sub = neg_q;
				ax  = '0;
			end
			default: ;
		endcase
		sum      = ax + (bx ^ {ADD_W{sub}}) + ADD_W'(sub);
		ge       = !sum[ADD_W-1];
		acc_next = b_q[0] ? sum[DATA_WIDTH-1:0] : rem_q;
		l_abs    = l_in[DATA_WIDTH-1] ? ('0 - l_in) : l_in;
		r_abs    = r_in[DATA_WIDTH-1] ? ('0 - r_in) : r_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= A_IDLE;
			status_q <= ST_OK;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			op_q     <= OP_ADD;
			a_q      <= '0;
			b_q      <= '0;
			rem_q    <= '0;
			res_q    <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						rem_q <= '0;
						cnt_q <= CNT_W'(DATA_WIDTH - 1);
						neg_q <= l_in[DATA_WIDTH-1] ^ r_in[DATA_WIDTH-1];
						if (!req.has_op) begin
							res_q    <= '0;
							status_q <= ST_NO_OP;
							state_q  <= A_DONE;
						end else begin
							case (req.op)
								OP_ADD, OP_SUB: begin
									a_q      <= l_in;
									b_q      <= r_in;
									status_q <= ST_OK;
									state_q  <= A_ADDSUB;
								end
								OP_MUL: begin
									a_q      <= l_in;
									b_q      <= r_in;
									status_q <= ST_OK;
									state_q  <= A_MUL;
								end
								OP_DIV: begin
									if (r_in == '0) begin
										res_q    <= '0;
										status_q <= ST_DIV_ZERO;
										state_q  <= A_DONE;
									end else begin
										a_q      <= l_abs;
										b_q      <= r_abs;
										status_q <= ST_OK;
										state_q  <= A_DIV;
									end
								end
								default: state_q <= A_IDLE;
							endcase
						end
					end
				end
				A_ADDSUB: begin
					res_q   <= sum[DATA_WIDTH-1:0];
					state_q <= A_DONE;
				end
				A_MUL: begin
					// shift-add, low half of the product only
					rem_q <= acc_next;
					a_q   <= {a_q[DATA_WIDTH-2:0], 1'b0};
					b_q   <= {1'b0, b_q[DATA_WIDTH-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						res_q   <= acc_next;
						state_q <= A_DONE;
					end
				end
				A_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q <= ge ? sum[DATA_WIDTH-1:0]
					            : {rem_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
					a_q   <= {a_q[DATA_WIDTH-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= A_SIGN;
				end
				A_SIGN: begin
					res_q   <= sum[DATA_WIDTH-1:0];
					state_q <= A_DONE;
				end
				A_DONE: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign res         = res_q;
	assign stat.busy   = (state_q != A_IDLE);
	assign stat.done   = (state_q == A_DONE);
	assign stat.status = status_q;

endmodule

/* rtl/core/char_stream_binary_expression_eval.sv */
// Two-operand decimal calculator fed one ASCII character per transaction.
// Blanks (space, tab) are skipped; a minus as the first kept character makes
// the left operand negative; the first of + - * / after that selects the
// operation and starts the right operand; any other non-digit is ignored.
// Digits accumulate modulo 2^DATA_WIDTH. The transaction with tlast set ends
// the line (its character is ignored) and yields one result transaction:
// tdata = left op right, wrapped to DATA_WIDTH bits, zero-extended or cut to
// 32 bits; tuser = status (0 ok, 1 no operator, 2 divide by zero; the data
// is 0 whenever status is not ok). Division truncates toward zero.
// Order of work: after a terminator is accepted the arithmetic unit goes
// straight to its done state (no operator, divide by zero), or runs one
// add/subtract step (add, subtract), one shift-add step per bit (multiply)
// or one restoring step per bit plus a sign fix (divide); every step uses
// the one shared add/subtract unit. The result is then registered on the
// master side. Input is not ready until the result shows there, and a
// terminator is also held off while an earlier result is still waiting on
// the master side; plain characters pass in that case.
module char_stream_binary_expression_eval import cse_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF    // operand width, 8..64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] char_in
	input  logic        s_axis_tlast,    // end_of_line
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,    // [31:0] result_value
	output logic [1:0]  m_axis_tuser     // [1:0] status
);

	logic                  in_fire;
	logic [DATA_WIDTH-1:0] left_val, right_val, alu_res;
	op_t                   op;
	logic                  has_op;
	cse_req_t              req;
	cse_alu_stat_t         stat;
	logic [EXT_W-1:0]      res_ext;

	logic                  out_valid_q;
	logic [RES_W-1:0]      out_data_q;
	status_t               out_status_q;

	// terminator needs a free output slot; characters only need an idle unit
	assign s_axis_tready = !stat.busy && !(s_axis_tlast && out_valid_q);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	cse_parser #(.DATA_WIDTH(DATA_WIDTH)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_en   (in_fire && !s_axis_tlast),
		.clear     (in_fire && s_axis_tlast),
		.char_in   (s_axis_tdata),
		.left_val  (left_val),
		.right_val (right_val),
		.op        (op),
		.has_op    (has_op)
	);

	assign req.start  = in_fire && s_axis_tlast;
	assign req.op     = op;
	assign req.has_op = has_op;

	cse_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.l_in   (left_val),
		.r_in   (right_val),
		.res    (alu_res),
		.stat   (stat)
	);

	assign res_ext = EXT_W'(alu_res);

	// output register; slot is always free when the unit finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_data_q   <= res_ext[RES_W-1:0];
			out_status_q <= stat.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule

/* rtl/core/cse_checker.sv */
`include "char_stream_binary_expression_eval_macros.svh"

module cse_checker import cse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic line_end;
	assign line_end = s_axis_tvalid && s_axis_tready && s_axis_tlast;

	// error results carry zero data
	`CSE_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0, "error status with nonzero data")

	// evaluation keeps the input side closed
	`CSE_ASSERT_NEXT(a_busy_after_eol, line_end, !s_axis_tready, "input ready right after line end")

	// no second line end while a result waits
	`CSE_ASSERT_NOW(a_no_overrun, m_axis_tvalid, !line_end, "line end taken while result pending")

	// stalled result holds
	`CSE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind char_stream_binary_expression_eval cse_checker u_cse_checker (.*);

/* bench/char_stream_binary_expression_eval_tb.sv */
module char_stream_binary_expression_eval_tb;
	import cse_pkg::*;

	// Receiver hold-off length, settle time after the last result (the slowest
	// terminator is a divide), and the no-progress watchdog limit.
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = DATA_WIDTH_DEF + 8;
	localparam int STUCK_LIMIT  = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] char_in
	logic        s_axis_tlast = 1'b0;      // end_of_line
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;             // [31:0] result_value
	logic [1:0]  m_axis_tuser;             // [1:0] status

	char_stream_binary_expression_eval dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ------------------------------------------------------------------
	// Calculator model: mirrors the parser state, updated on every input
	// transaction the block accepts. A terminator pushes one expected result.
	// ------------------------------------------------------------------
	typedef struct {
		logic [31:0] value;
		status_t     st;
	} calc_result_t;

	calc_result_t pending_results[$];

	logic [31:0] lhs_acc = '0;
	logic [31:0] rhs_acc = '0;
	op_t         pend_op = OP_ADD;
	logic        seen_op = 1'b0;
	logic        lhs_neg = 1'b0;
	logic        seen_kept = 1'b0;

	int err_count = 0;
	int items_sent = 0;

	task automatic calc_absorb(input logic [7:0] ch, input logic eol);
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] la;
		logic [31:0] ra;
		logic [31:0] q;
		calc_result_t res;
		if (eol) begin
			l = lhs_neg ? 32'd0 - lhs_acc : lhs_acc;
			r = rhs_acc;
			res.value = '0;
			res.st = ST_OK;
			if (!seen_op) begin
				res.st = ST_NO_OP;
			end else begin
				case (pend_op)
					OP_ADD: res.value = l + r;
					OP_SUB: res.value = l - r;
					OP_MUL: res.value = l * r;
					default: begin
						if (r == '0) begin
							res.st = ST_DIV_ZERO;
						end else begin
							// magnitude divide, then sign fix; truncates toward zero
							la = l[31] ? 32'd0 - l : l;
							ra = r[31] ? 32'd0 - r : r;
							q = la / ra;
							res.value = (l[31] != r[31]) ? 32'd0 - q : q;
						end
					end
				endcase
			end
			pending_results.push_back(res);
			lhs_acc = '0;
			rhs_acc = '0;
			pend_op = OP_ADD;
			seen_op = 1'b0;
			lhs_neg = 1'b0;
			seen_kept = 1'b0;
		end else if (ch == CH_SPACE || ch == CH_TAB) begin
			// blanks skipped entirely
		end else if (!seen_op) begin
			if (!seen_kept && ch == CH_MINUS) begin
				lhs_neg = 1'b1;
			end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_MUL || ch == CH_DIV) begin
				case (ch)
					CH_PLUS:  pend_op = OP_ADD;
					CH_MINUS: pend_op = OP_SUB;
					CH_MUL:   pend_op = OP_MUL;
					default:  pend_op = OP_DIV;
				endcase
				seen_op = 1'b1;
			end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
				lhs_acc = lhs_acc * 32'd10 + {24'd0, ch - CH_ZERO};
			end
			seen_kept = 1'b1;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			// after the operator only digits matter
			rhs_acc = rhs_acc * 32'd10 + {24'd0, ch - CH_ZERO};
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: feeds accepted input transactions to the model and checks
	// each accepted result transaction against the oldest expectation.
	// Sampled at the rising edge, so pre-edge values are seen.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		calc_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				calc_absorb(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected: value %h status %0d",
						$time, m_axis_tdata, m_axis_tuser);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tdata !== want.value) begin
						$display("%0t: result_value expected %h actual %h",
							$time, want.value, m_axis_tdata);
						err_count++;
					end
					if (m_axis_tuser !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, m_axis_tuser);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog: cycles in a row with no transaction on either side.
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
			$display("char_stream_binary_expression_eval_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: tready follows a pattern that changes style at random
	// intervals (always ready, coin flip, rare stall, mostly stalled).
	// A hold-off request from a test blanks tready for a span set by HOLD_CYCLES.
	// ------------------------------------------------------------------
	int hold_asks = 0;
	int hold_served = 0;
	int hold_left = 0;
	int rx_style = 0;
	int rx_phase_left = 0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asks) begin
			m_axis_tready <= 1'b0;
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			if (rx_phase_left == 0) begin
				rx_style <= $urandom_range(0, 3);
				rx_phase_left <= $urandom_range(16, 96);
			end else begin
				rx_phase_left <= rx_phase_left - 1;
			end
			case (rx_style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Character side. Bursts of random length with random gaps between them;
	// tvalid stays high across back-to-back characters.
	// ------------------------------------------------------------------
	bit tx_gaps_on = 1'b1;
	int tx_burst_left = 0;

	task automatic send_char(input logic [7:0] ch, input logic eol);
		int gap;
		gap = 0;
		if (tx_gaps_on) begin
			if (tx_burst_left == 0) begin
				tx_burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
			end else begin
				tx_burst_left--;
			end
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= eol;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (eol || (ch != CH_SPACE && ch != CH_TAB))
			items_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	// terminator; its character is don't-care for the block
	task automatic end_line(input logic [7:0] ch);
		send_char(ch, 1'b1);
	endtask

	// occasional blank between tokens
	task automatic maybe_blank();
		if ($urandom_range(0, 3) == 0)
			send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
	endtask

	task automatic send_digits(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
	endtask

	// mostly 0..4 digits, sometimes long enough to wrap 32 bits
	function automatic int pick_len();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
	endfunction

	task automatic send_random_line();
		int kind;
		logic [7:0] op_ch;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: op_ch = CH_PLUS;
			1: op_ch = CH_MINUS;
			2: op_ch = CH_MUL;
			default: op_ch = CH_DIV;
		endcase
		if (kind < 65) begin
			// well-formed: [-] left op right, with blanks and junk sprinkled in
			maybe_blank();
			if ($urandom_range(0, 2) == 0)
				send_char(CH_MINUS, 1'b0);
			maybe_blank();
			send_digits(pick_len());
			if ($urandom_range(0, 7) == 0)
				send_char(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
			maybe_blank();
			send_char(op_ch, 1'b0);
			maybe_blank();
			if ($urandom_range(0, 5) == 0)
				send_digits($urandom_range(0, 1));
			else
				send_digits(pick_len());
			// a second operator is just another ignored character
			if ($urandom_range(0, 5) == 0) begin
				send_char(op_ch, 1'b0);
				send_digits($urandom_range(0, 3));
			end
		end else if (kind < 75) begin
			case ($urandom_range(0, 4))
				0: send_text("-2147483648/4294967295");   // most negative by minus one
				1: send_text("2147483647*2");
				2: send_text("4294967295+1");
				3: send_text("-2147483648-1");
				default: begin
					send_digits($urandom_range(1, 6));
					send_text("/00");                      // divide by zero
				end
			endcase
		end else if (kind < 85) begin
			// no operator: digits and non-operator junk only
			send_digits(pick_len());
			send_char(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
			send_digits($urandom_range(0, 3));
		end else begin
			// raw noise over the full byte range
			repeat ($urandom_range(0, 10)) send_char(8'($urandom_range(0, 255)), 1'b0);
		end
		end_line(8'($urandom_range(0, 255)));
	endtask

	// Drop tvalid, wait for every outstanding result, then let the block settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Extremes of the character byte, all four operators and the named
	// corner cases: empty line, leading minus then minus, divide by zero,
	// truncation of a negative quotient, operator as last kept character.
	task automatic test_directed();
		tx_gaps_on = 1'b0;
		end_line(8'hFF);                 // empty line
		send_text("-5-3");
		end_line(CH_ZERO);
		send_text("7/0");
		end_line(CH_SPACE);
		send_text("-7/2");
		end_line(8'h00);
		send_text("\t8+ ");
		end_line(CH_MINUS);
		send_char(8'h00, 1'b0);          // ignored before the operator
		send_text("*3");
		end_line(8'hA5);
	endtask

	task automatic test_random(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			// some lines with no sender gaps at all
			tx_gaps_on = ($urandom_range(0, 4) != 0);
			send_random_line();
		end
	endtask

	// Result side held off while lines keep coming: the first result parks on
	// the output, the next terminator backs up the input.
	task automatic test_backpressure();
		hold_asks <= hold_asks + 1;
		tx_gaps_on = 1'b0;
		repeat (4) send_random_line();
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_idle();
		test_random(260);
		wait_idle();
		test_backpressure();
		test_random(200);
		wait_idle();
		if (err_count == 0)
			$display("char_stream_binary_expression_eval_tb: clean");
		else
			$display("char_stream_binary_expression_eval_tb: errors");
		$finish;
	end

endmodule

/* char_stream_binary_expression_eval.f */
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cse_parser.sv
rtl/core/cse_alu.sv
rtl/core/char_stream_binary_expression_eval.sv
rtl/core/cse_checker.sv
bench/char_stream_binary_expression_eval_tb.sv
